/* src/assert_macros.svh */
// Assertion macros shared by the box blur RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define BB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("box blur assertion failed");
// Checked on every rising clock edge, reset included.
`define BB_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("box blur assertion failed");
`else
`define BB_ASSERT(name, clk, rst_n, prop)
`define BB_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* src/bb_pkg.sv */
// Shared types and constants of the 3x3 box blur stream.
package bb_pkg;

  // Register port and field widths.
  localparam int CFG_DATA_BITS    = 13;
  localparam int WIDTH_REG_BITS   = 11;
  localparam int HEIGHT_BITS      = 13;
  localparam int IN_PIXEL_BITS    = 8;
  localparam int OUT_PIXEL_BITS   = 8;

  // Frame geometry limits and reset values.
  localparam int MIN_DIM          = 3;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int WIDTH_RESET      = 640;
  localparam int HEIGHT_RESET     = 480;

  // Row counters: the input row runs past the last row while draining.
  localparam int IN_ROW_BITS      = 13;
  localparam int OUT_ROW_BITS     = 12;

  // Window geometry and the mean divisor.
  localparam int WIN_DIM          = 3;
  localparam int WIN_CELLS        = 9;
  localparam int MEAN_DIVISOR     = 9;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Input item kinds.
  typedef enum logic [0:0] {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // Per-item control decided at the input and carried down the pipeline.
  typedef struct packed {
    logic emit;
    logic use_mean;
    logic last;
  } bb_flags_t;

endpackage

/* src/bb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module bb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bb_ctrl.sv */
// Input stage: configuration, position counters and per-item control.
`include "assert_macros.svh"

module bb_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_index_i,
  input  logic [bb_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic [bb_pkg::IN_PIXEL_BITS-1:0]   pixel_value_i,
  input  logic                               s2_ready_i,
  output logic                               s1_valid_o,
  output logic [PIXEL_BITS-1:0]              s1_pix_o,
  output logic [CW-1:0]                      s1_idx_o,
  output bb_pkg::bb_flags_t                  s1_flags_o,
  output logic                               rd_en_o,
  output logic [CW-1:0]                      rd_addr_o
);

  import bb_pkg::*;

  function automatic logic [WW-1:0] clamp_width(input logic [WIDTH_REG_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide < 32'(MIN_DIM)) begin
      wide = 32'(MIN_DIM);
    end else if (wide > 32'(MAX_WIDTH)) begin
      wide = 32'(MAX_WIDTH);
    end
    return WW'(wide);
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide < 32'(MIN_DIM)) begin
      wide = 32'(MIN_DIM);
    end else if (wide > 32'(HEIGHT_LIMIT)) begin
      wide = 32'(HEIGHT_LIMIT);
    end
    return HEIGHT_BITS'(wide);
  endfunction

  logic [WW-1:0]           width_q;
  logic [HEIGHT_BITS-1:0]  height_q;
  logic [CW-1:0]           in_col_q, in_col_d;
  logic [IN_ROW_BITS-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]           out_col_q, out_col_d;
  logic [OUT_ROW_BITS-1:0] out_row_q, out_row_d;

  logic                    s1_valid_q;
  logic [PIXEL_BITS-1:0]   s1_pix_q;
  logic [CW-1:0]           s1_idx_q;
  bb_flags_t               s1_flags_q;

  logic                    s1_ready;
  logic                    accept;
  logic                    draining;
  logic                    drop;
  logic                    load;
  logic [PIXEL_BITS-1:0]   pix_d;
  bb_flags_t               flags_d;
  logic                    interior;
  logic [WW-1:0]           in_col_inc;
  logic [WW-1:0]           out_col_inc;
  logic [WW:0]             out_col_ext;
  logic [HEIGHT_BITS:0]    out_row_ext;

  // Configuration registers hold the clamped geometry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_width(WIDTH_REG_BITS'(WIDTH_RESET));
      height_q <= clamp_height(HEIGHT_BITS'(HEIGHT_RESET));
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= clamp_width(cfg_data_i[WIDTH_REG_BITS-1:0]);
        CFG_IMAGE_HEIGHT: height_q <= clamp_height(cfg_data_i[HEIGHT_BITS-1:0]);
      endcase
    end
  end

  // Handshake: a drain tick that arrives before the frame is complete is
  // taken and discarded.
  assign s1_ready   = !s1_valid_q || s2_ready_i;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;
  assign draining   = in_row_q >= height_q;
  assign drop       = (func_e'(func_i) == FUNC_DRAIN) && !draining;
  assign load       = accept && !drop;

  // Pixel value, zero once every row has arrived.
  assign pix_d = draining ? '0 : PIXEL_BITS'(pixel_value_i);

  // Output position decides border handling and the frame end.
  assign out_col_ext = (WW + 1)'(out_col_q);
  assign out_row_ext = (HEIGHT_BITS + 1)'(out_row_q);
  assign interior = (out_row_q != '0) &&
                    (out_row_ext + (HEIGHT_BITS + 1)'(2) <= (HEIGHT_BITS + 1)'(height_q)) &&
                    (out_col_q != '0) &&
                    (out_col_ext + (WW + 1)'(2) <= (WW + 1)'(width_q));

  always_comb begin
    flags_d.emit     = (in_row_q >= IN_ROW_BITS'(2)) ||
                       ((in_row_q == IN_ROW_BITS'(1)) && (in_col_q != '0));
    flags_d.use_mean = (in_col_q != '0) && interior;
    flags_d.last     = (out_row_ext + (HEIGHT_BITS + 1)'(1) >= (HEIGHT_BITS + 1)'(height_q)) &&
                       (out_col_ext + (WW + 1)'(1) >= (WW + 1)'(width_q));
  end

  assign in_col_inc  = WW'(in_col_q) + WW'(1);
  assign out_col_inc = WW'(out_col_q) + WW'(1);

  // Next values of the input and output position counters.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (load) begin
      if (in_col_inc >= width_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + IN_ROW_BITS'(1);
      end else begin
        in_col_d = CW'(in_col_inc);
      end
      if (flags_d.emit) begin
        if (out_col_inc >= width_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + OUT_ROW_BITS'(1);
        end else begin
          out_col_d = CW'(out_col_inc);
        end
        if (flags_d.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= load || (s1_valid_q && !s2_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_pix_q   <= pix_d;
      s1_idx_q   <= in_col_q;
      s1_flags_q <= flags_d;
    end
  end

  // Line store read for the item that is loaded; data arrives with the input register.
  assign rd_en_o    = load;
  assign rd_addr_o  = in_col_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_pix_o   = s1_pix_q;
  assign s1_idx_o   = s1_idx_q;
  assign s1_flags_o = s1_flags_q;

  // The frame end returns every position counter to the frame start.
  `BB_ASSERT(a_last_clears_counters, clk_i, rst_ni,
             load && flags_d.emit && flags_d.last |=>
               in_col_q == '0 && in_row_q == '0 &&
               out_col_q == '0 && out_row_q == '0)
  // A discarded drain tick leaves the frame position alone.
  `BB_ASSERT(a_drop_keeps_position, clk_i, rst_ni,
             accept && drop |=> $stable(in_row_q) && $stable(in_col_q))

endmodule

/* src/bb_window.sv */
// Neighborhood window and nine-pixel sum stage.
`include "assert_macros.svh"

module bb_window #(
  parameter int PIXEL_BITS = 8,
  localparam int SW = PIXEL_BITS + 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s1_valid_i,
  input  logic [PIXEL_BITS-1:0] s1_pix_i,
  input  bb_pkg::bb_flags_t     s1_flags_i,
  input  logic [PIXEL_BITS-1:0] upper_rd_i,
  input  logic [PIXEL_BITS-1:0] middle_rd_i,
  output logic                  s2_ready_o,
  input  logic                  dn_ready_i,
  output logic                  s3_valid_o,
  output logic [SW-1:0]         s3_sum_o,
  output logic [PIXEL_BITS-1:0] s3_center_o,
  output bb_pkg::bb_flags_t     s3_flags_o
);

  import bb_pkg::*;

  localparam logic [SW-1:0] SUM_MAX = SW'(WIN_CELLS * ((1 << PIXEL_BITS) - 1));

  logic [PIXEL_BITS-1:0] win_q [WIN_CELLS];
  logic                  s2_valid_q;
  bb_flags_t             s2_flags_q;
  logic                  s3_valid_q;
  logic [SW-1:0]         s3_sum_q;
  logic [PIXEL_BITS-1:0] s3_center_q;
  bb_flags_t             s3_flags_q;

  logic                  s3_ready;
  logic                  s2_ready;
  logic                  s1_move;
  logic                  s2_move;
  logic                  s3_load;
  logic [SW-1:0]         sum_d;

  assign s3_ready   = !s3_valid_q || dn_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_move    = s1_valid_i && s2_ready;
  assign s2_move    = s2_valid_q && s3_ready;
  assign s3_load    = s2_move && s2_flags_q.emit;
  assign s2_ready_o = s2_ready;

  // Window shifts left; the right column takes both line stores and the new pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_CELLS; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_move) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        win_q[r * WIN_DIM]     <= win_q[r * WIN_DIM + 1];
        win_q[r * WIN_DIM + 1] <= win_q[r * WIN_DIM + 2];
      end
      win_q[2] <= upper_rd_i;
      win_q[5] <= middle_rd_i;
      win_q[8] <= s1_pix_i;
    end
  end

  // Window stage control; items without a result stop here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_move || (s2_valid_q && !s3_ready);
      s3_valid_q <= s3_load || (s3_valid_q && !dn_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_flags_q <= s1_flags_i;
    end
  end

  // Sum of the nine window cells.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      sum_d = sum_d + SW'(win_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_sum_q    <= sum_d;
      s3_center_q <= win_q[4];
      s3_flags_q  <= s2_flags_q;
    end
  end

  assign s3_valid_o  = s3_valid_q;
  assign s3_sum_o    = s3_sum_q;
  assign s3_center_o = s3_center_q;
  assign s3_flags_o  = s3_flags_q;

  // A held sum is always within nine full-scale pixels.
  `BB_ASSERT(a_sum_in_range, clk_i, rst_ni, s3_valid_q |-> s3_sum_q <= SUM_MAX)

endmodule

/* src/bb_mean.sv */
// Output stage: divide by nine and the result register.
module bb_mean #(
  parameter int PIXEL_BITS = 8,
  localparam int SW = PIXEL_BITS + 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s3_valid_i,
  input  logic [SW-1:0]                     s3_sum_i,
  input  logic [PIXEL_BITS-1:0]             s3_center_i,
  input  bb_pkg::bb_flags_t                 s3_flags_i,
  output logic                              s3_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bb_pkg::OUT_PIXEL_BITS-1:0] blurred_pixel_o,
  output logic                              frame_end_o
);

  import bb_pkg::*;

  // Reciprocal of nine, exact for every sum that fits in SW bits.
  localparam int SHIFT = SW + 4;
  localparam int RW    = SW + 1;
  localparam int PW    = SW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SHIFT) + 64'(MEAN_DIVISOR - 1)) / 64'(MEAN_DIVISOR));

  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_last_q;

  logic                  out_load;
  logic [PW-1:0]         prod;
  logic [PIXEL_BITS-1:0] mean;
  logic [PIXEL_BITS-1:0] pix_d;

  assign s3_ready_o = !out_valid_q || out_ready_i;
  assign out_load   = s3_valid_i && s3_ready_o;

  // Multiply by the reciprocal; the quotient sits above the shift point.
  assign prod  = PW'(s3_sum_i) * PW'(RECIP);
  assign mean  = prod[SHIFT +: PIXEL_BITS];
  assign pix_d = s3_flags_i.use_mean ? mean : s3_center_i;

  // Result register: holds while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= pix_d;
      out_last_q <= s3_flags_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_pixel_o = out_pix_q[OUT_PIXEL_BITS-1:0];
  assign frame_end_o     = out_last_q;

endmodule

/* src/box_blur_3x3_stream.sv */
// Top level of the streaming 3x3 box blur.
//
// Pixels enter in raster order on the input channel (func 0 = pixel, func 1 =
// drain tick); results leave on the output channel, both with valid/ready.
// Each interior pixel becomes the truncated mean of its 3x3 neighborhood; the
// first and last row and column pass through unchanged. frame_end marks the
// last pixel of a frame. Results lag the input stream by one row plus one pixel,
// so after the last pixel the sender gives image_width + 1 drain ticks. A drain
// tick sent while the frame is still arriving is taken and dropped. Geometry must
// be written through the configuration port only while the block is idle; the
// sender keeps to this, as the block does not enforce it. One item is taken every
// clock unless stalled. Results pass the input register with the line store reads,
// the window with the line store writes, the nine-pixel sum and the divide by nine
// into the output register. When the receiver stalls, results hold and up to four
// items stay in flight before ready drops. Reset clears counters and pipeline and
// loads a 640 x 480 geometry; the line stores are not cleared and need no pass.
`include "assert_macros.svh"

module box_blur_3x3_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [bb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [bb_pkg::IN_PIXEL_BITS-1:0]  pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bb_pkg::OUT_PIXEL_BITS-1:0] blurred_pixel_o,
  output logic                              frame_end_o
);

  import bb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = PIXEL_BITS + 4;

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [CW-1:0]         s1_idx;
  bb_flags_t             s1_flags;
  logic                  s2_ready;
  logic                  rd_en;
  logic [CW-1:0]         rd_addr;
  logic                  wr_en;
  logic [PIXEL_BITS-1:0] upper_rd;
  logic [PIXEL_BITS-1:0] middle_rd;
  logic                  s3_valid;
  logic                  s3_ready;
  logic [SW-1:0]         s3_sum;
  logic [PIXEL_BITS-1:0] s3_center;
  bb_flags_t             s3_flags;

  // Input stage.
  bb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pixel_value_i (pixel_value_i),
    .s2_ready_i    (s2_ready),
    .s1_valid_o    (s1_valid),
    .s1_pix_o      (s1_pix),
    .s1_idx_o      (s1_idx),
    .s1_flags_o    (s1_flags),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  // Line stores: the middle row moves up and the new pixel enters the middle
  // row when the item leaves the input register.
  assign wr_en = s1_valid && s2_ready;

  bb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (middle_rd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (upper_rd)
  );

  bb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle_row (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (s1_pix),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (middle_rd)
  );

  // Window and sum.
  bb_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_pix_i    (s1_pix),
    .s1_flags_i  (s1_flags),
    .upper_rd_i  (upper_rd),
    .middle_rd_i (middle_rd),
    .s2_ready_o  (s2_ready),
    .dn_ready_i  (s3_ready),
    .s3_valid_o  (s3_valid),
    .s3_sum_o    (s3_sum),
    .s3_center_o (s3_center),
    .s3_flags_o  (s3_flags)
  );

  // Divide and result register.
  bb_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s3_valid_i      (s3_valid),
    .s3_sum_i        (s3_sum),
    .s3_center_i     (s3_center),
    .s3_flags_i      (s3_flags),
    .s3_ready_o      (s3_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blurred_pixel_o (blurred_pixel_o),
    .frame_end_o     (frame_end_o)
  );

  // Reset seen held at the clock leaves no result offered in the cycle after.
  `BB_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |=> !out_valid_o)
  // A rising result valid always comes from a sum held in the cycle before.
  `BB_ASSERT(a_result_from_sum, clk_i, rst_ni, $rose(out_valid_o) |-> $past(s3_valid))
  // Input back-pressure only arises with the input register occupied.
  `BB_ASSERT(a_stall_needs_item, clk_i, rst_ni, !in_ready_o |-> s1_valid)

endmodule
